[src/udlc_pkg.sv]
package udlc_pkg;

   // default sizes
   localparam int NUMBER_WIDTH_DEFAULT = 32;
   localparam int COUNT_WIDTH_DEFAULT  = 16;
   localparam int QUEUE_DEPTH          = 4;
   localparam int LENGTH_WIDTH         = 16;
   localparam int CSR_INDEX_WIDTH      = 4;
   localparam int CSR_DATA_WIDTH       = 16;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_LENGTH_LIMIT = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_COUNT_LIMIT  = CSR_INDEX_WIDTH'(1);

   // register reset values
   localparam logic [CSR_DATA_WIDTH-1:0] LINE_LENGTH_LIMIT_RESET = 16'd256;
   localparam logic [CSR_DATA_WIDTH-1:0] LINE_COUNT_LIMIT_RESET  = 16'd4096;

   // line kinds
   localparam logic [2:0] KIND_HUNK   = 3'd0;
   localparam logic [2:0] KIND_HEADER = 3'd1;
   localparam logic [2:0] KIND_ADD    = 3'd2;
   localparam logic [2:0] KIND_DEL    = 3'd3;
   localparam logic [2:0] KIND_CTX    = 3'd4;

   // characters
   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_NL    = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_AT    = 8'd64;
   localparam logic [7:0] CHAR_D     = 8'd100;
   localparam logic [7:0] CHAR_I     = 8'd105;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;

   // line prefix match state
   typedef enum logic [3:0] {
      PS_START   = 4'd0,
      PS_M_AT    = 4'd1,
      PS_M_DIFF  = 4'd2,
      PS_M_INDEX = 4'd3,
      PS_M_DASH  = 4'd4,
      PS_M_PLUS  = 4'd5,
      PS_HUNK    = 4'd6,
      PS_HEADER  = 4'd7,
      PS_ADD     = 4'd8,
      PS_DEL     = 4'd9,
      PS_CTX     = 4'd10
   } prefix_type;

   // hunk header parse phase
   typedef enum logic [3:0] {
      HP_IDLE       = 4'd0,
      HP_WS         = 4'd1,
      HP_OLD_FIRST  = 4'd2,
      HP_OLD_DIGITS = 4'd3,
      HP_SKIP       = 4'd4,
      HP_NEW_FIRST  = 4'd5,
      HP_NEW_DIGITS = 4'd6,
      HP_DONE       = 4'd7,
      HP_FAIL       = 4'd8
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  line_kind;
      logic [31:0] old_number;
      logic [31:0] new_number;
      logic [15:0] hunk_total;
      logic [15:0] addition_total;
      logic [15:0] deletion_total;
      logic        parse_status;
      logic        text_done;
   } rsp_payload_type;

   // one finished line or end-of-text mark, front to back
   typedef struct packed {
      logic                    emit;
      logic                    eot;
      logic                    hdr_ok;
      logic [2:0]              kind;
      logic [LENGTH_WIDTH-1:0] length;
   } line_event_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // length of the prefix word a match state looks for
   function automatic logic [2:0] word_length(input prefix_type ps);
      logic [2:0] len;
      unique case (ps)
         PS_M_AT:    len = 3'd3;
         PS_M_DIFF:  len = 3'd5;
         PS_M_INDEX: len = 3'd6;
         PS_M_DASH:  len = 3'd3;
         PS_M_PLUS:  len = 3'd3;
         default:    len = 3'd0;
      endcase
      return len;
   endfunction

   // byte of the prefix word at a position
   function automatic logic [7:0] word_char(input prefix_type ps, input logic [2:0] idx);
      logic [63:0] word;
      logic [63:0] shifted;
      unique case (ps)
         PS_M_AT:    word = {"@@ ", 40'h0};
         PS_M_DIFF:  word = {"diff ", 24'h0};
         PS_M_INDEX: word = {"index ", 16'h0};
         PS_M_DASH:  word = {"---", 40'h0};
         PS_M_PLUS:  word = {"+++", 40'h0};
         default:    word = 64'h0;
      endcase
      shifted = word << {idx, 3'b000};
      return shifted[63:56];
   endfunction

endpackage

[src/udlc_queue.sv]
module udlc_queue
   import udlc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   // status
   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/udlc_front.sv]
module udlc_front
   import udlc_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_accept,
   input  req_payload_type         byte_payload,
   output logic                    ev_valid,
   output line_event_type          ev,
   output logic [NUMBER_WIDTH-1:0] ev_parsed_old,
   output logic [NUMBER_WIDTH-1:0] ev_parsed_new
);

   localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = {NUMBER_WIDTH{1'b1}};

   prefix_type              prefix_ff, prefix_in;
   phase_type               phase_ff, phase_in;
   logic [LENGTH_WIDTH-1:0] len_ff, len_in;
   logic [NUMBER_WIDTH-1:0] old_ff, old_in;
   logic [NUMBER_WIDTH-1:0] new_ff, new_in;
   logic [7:0]              c;
   logic                    eot, real_char, line_end;
   logic [2:0]              wlen;
   logic                    word_hit;
   logic [2:0]              kind;

   // saturating decimal accumulate
   function automatic logic [NUMBER_WIDTH-1:0] accumulate(
      input logic [NUMBER_WIDTH-1:0] v, input logic [7:0] d);
      logic [NUMBER_WIDTH+3:0] wide;
      logic [NUMBER_WIDTH+3:0] digit;
      digit = (NUMBER_WIDTH+4)'(d - CHAR_ZERO);
      wide  = ({4'b0, v} << 3) + ({4'b0, v} << 1) + digit;
      return (wide[NUMBER_WIDTH+3:NUMBER_WIDTH] != '0) ? NUM_MAX : wide[NUMBER_WIDTH-1:0];
   endfunction

   assign c         = byte_payload.text_byte;
   assign eot       = byte_payload.end_of_text;
   assign real_char = (c != CHAR_NL) && (c != CHAR_NUL);
   assign wlen      = word_length(prefix_ff);
   assign word_hit  = (len_ff < LENGTH_WIDTH'(wlen)) && (c == word_char(prefix_ff, len_ff[2:0]));

   // next state: prefix match, header parse, line length
   always_comb begin
      prefix_in = prefix_ff;
      phase_in  = phase_ff;
      old_in    = old_ff;
      new_in    = new_ff;
      len_in    = len_ff;
      if (real_char) begin
         len_in = (len_ff != '1) ? len_ff + 1'b1 : len_ff;
         priority if (prefix_ff == PS_HUNK) begin
            unique case (phase_ff)
               HP_WS: begin
                  if (c == CHAR_MINUS) phase_in = HP_OLD_FIRST;
                  else if (!is_space(c)) phase_in = HP_FAIL;
               end
               HP_OLD_FIRST: begin
                  if (is_digit(c)) begin
                     old_in   = accumulate('0, c);
                     phase_in = HP_OLD_DIGITS;
                  end else if (!is_space(c)) begin
                     phase_in = HP_FAIL;
                  end
               end
               HP_OLD_DIGITS: begin
                  if (is_digit(c)) old_in = accumulate(old_ff, c);
                  else phase_in = (c == CHAR_PLUS) ? HP_FAIL : HP_SKIP;
               end
               HP_SKIP: begin
                  if (c == CHAR_PLUS) phase_in = HP_NEW_FIRST;
               end
               HP_NEW_FIRST: begin
                  if (is_digit(c)) begin
                     new_in   = accumulate('0, c);
                     phase_in = HP_NEW_DIGITS;
                  end else if (!is_space(c)) begin
                     phase_in = HP_FAIL;
                  end
               end
               HP_NEW_DIGITS: begin
                  if (is_digit(c)) new_in = accumulate(new_ff, c);
                  else phase_in = HP_DONE;
               end
               default: ;
            endcase
         end else if (prefix_ff == PS_START) begin
            priority if (c == CHAR_AT) prefix_in = PS_M_AT;
            else if (c == CHAR_D) prefix_in = PS_M_DIFF;
            else if (c == CHAR_I) prefix_in = PS_M_INDEX;
            else if (c == CHAR_MINUS) prefix_in = PS_M_DASH;
            else if (c == CHAR_PLUS) prefix_in = PS_M_PLUS;
            else prefix_in = PS_CTX;
         end else if (wlen != 3'd0) begin
            priority if (word_hit) begin
               if (len_ff + 1'b1 == LENGTH_WIDTH'(wlen)) begin
                  if (prefix_ff == PS_M_AT) begin
                     prefix_in = PS_HUNK;
                     phase_in  = HP_WS;
                  end else begin
                     prefix_in = PS_HEADER;
                  end
               end
            end else if (prefix_ff == PS_M_DASH && len_ff == LENGTH_WIDTH'(1)) begin
               prefix_in = PS_DEL;
            end else if (prefix_ff == PS_M_PLUS && len_ff == LENGTH_WIDTH'(1)) begin
               prefix_in = PS_ADD;
            end else begin
               prefix_in = PS_CTX;
            end
         end else begin
            prefix_in = prefix_ff;
         end
      end
   end

   // line end and its kind
   assign line_end = (c == CHAR_NL) || (eot && (len_in != '0));

   always_comb begin
      priority if (prefix_in == PS_HUNK) begin
         kind = KIND_HUNK;
      end else if (prefix_in == PS_HEADER) begin
         kind = KIND_HEADER;
      end else if (prefix_in == PS_ADD ||
                   (prefix_in == PS_M_PLUS && len_in == LENGTH_WIDTH'(1))) begin
         kind = KIND_ADD;
      end else if (prefix_in == PS_DEL ||
                   (prefix_in == PS_M_DASH && len_in == LENGTH_WIDTH'(1))) begin
         kind = KIND_DEL;
      end else begin
         kind = KIND_CTX;
      end
   end

   // event toward the back end
   always_comb begin
      ev_valid      = byte_accept && (line_end || eot);
      ev.emit       = line_end;
      ev.eot        = eot;
      ev.hdr_ok     = (phase_in == HP_NEW_DIGITS) || (phase_in == HP_DONE);
      ev.kind       = kind;
      ev.length     = len_in;
      ev_parsed_old = old_in;
      ev_parsed_new = new_in;
   end

   // per-line state, cleared at each line end and text end
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= PS_START;
         phase_ff  <= HP_IDLE;
         len_ff    <= '0;
         old_ff    <= '0;
         new_ff    <= '0;
      end else if (byte_accept) begin
         if (line_end || eot) begin
            prefix_ff <= PS_START;
            phase_ff  <= HP_IDLE;
            len_ff    <= '0;
            old_ff    <= '0;
            new_ff    <= '0;
         end else begin
            prefix_ff <= prefix_in;
            phase_ff  <= phase_in;
            len_ff    <= len_in;
            old_ff    <= old_in;
            new_ff    <= new_in;
         end
      end
   end

endmodule

[src/udlc_back.sv]
module udlc_back
   import udlc_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       ev_valid,
   input  line_event_type             ev,
   input  logic [NUMBER_WIDTH-1:0]    ev_parsed_old,
   input  logic [NUMBER_WIDTH-1:0]    ev_parsed_new,
   output logic                       ev_ready,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload
);

   logic [CSR_DATA_WIDTH-1:0] len_limit_ff, cnt_limit_ff;
   logic [LENGTH_WIDTH-1:0]   lines_ff, lines_in;
   logic [NUMBER_WIDTH-1:0]   old_ff, old_in, new_ff, new_in;
   logic [COUNT_WIDTH-1:0]    hunk_ff, hunk_in, add_ff, add_in, del_ff, del_in;
   logic                      stopped_ff, stopped_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;
   logic                      take, produce, over;
   logic [NUMBER_WIDTH-1:0]   old_shown, new_shown;

   // fit internal widths to the fixed result fields
   function automatic logic [31:0] number_field(input logic [NUMBER_WIDTH-1:0] v);
      logic [NUMBER_WIDTH+31:0] ext;
      ext = {32'b0, v};
      return ext[31:0];
   endfunction

   function automatic logic [15:0] count_field(input logic [COUNT_WIDTH-1:0] v);
      logic [COUNT_WIDTH+15:0] ext;
      ext = {16'b0, v};
      return ext[15:0];
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v != '1) ? v + 1'b1 : v;
   endfunction

   assign csr_ready   = 1'b1;
   assign ev_ready    = !rsp_valid_ff || !rsp_stall;
   assign take        = ev_valid && ev_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign over        = (ev.length >= len_limit_ff) || (lines_ff >= cnt_limit_ff);

   // line bookkeeping and result build
   always_comb begin
      lines_in   = lines_ff;
      old_in     = old_ff;
      new_in     = new_ff;
      hunk_in    = hunk_ff;
      add_in     = add_ff;
      del_in     = del_ff;
      stopped_in = stopped_ff;
      produce    = 1'b0;
      old_shown  = '0;
      new_shown  = '0;
      rsp_payload_in = rsp_payload_ff;
      if (take && !stopped_ff && ev.emit) begin
         produce = 1'b1;
         if (over) begin
            stopped_in = 1'b1;
         end else begin
            lines_in = (lines_ff != '1) ? lines_ff + 1'b1 : lines_ff;
            unique case (ev.kind)
               KIND_HUNK: begin
                  hunk_in = count_inc(hunk_ff);
                  if (ev.hdr_ok) begin
                     old_in = ev_parsed_old;
                     new_in = ev_parsed_new;
                  end
               end
               KIND_ADD: begin
                  new_shown = new_ff;
                  new_in    = new_ff + 1'b1;
                  add_in    = count_inc(add_ff);
               end
               KIND_DEL: begin
                  old_shown = old_ff;
                  old_in    = old_ff + 1'b1;
                  del_in    = count_inc(del_ff);
               end
               KIND_CTX: begin
                  old_shown = old_ff;
                  new_shown = new_ff;
                  old_in    = old_ff + 1'b1;
                  new_in    = new_ff + 1'b1;
               end
               default: ;
            endcase
         end
         rsp_payload_in.line_kind      = over ? KIND_HUNK : ev.kind;
         rsp_payload_in.old_number     = number_field(old_shown);
         rsp_payload_in.new_number     = number_field(new_shown);
         rsp_payload_in.hunk_total     = count_field(hunk_in);
         rsp_payload_in.addition_total = count_field(add_in);
         rsp_payload_in.deletion_total = count_field(del_in);
         rsp_payload_in.parse_status   = over;
         rsp_payload_in.text_done      = over || ev.eot;
      end
      // end of text returns all running state to reset
      if (take && ev.eot) begin
         lines_in   = '0;
         old_in     = '0;
         new_in     = '0;
         hunk_in    = '0;
         add_in     = '0;
         del_in     = '0;
         stopped_in = 1'b0;
      end
      rsp_valid_in = produce || (rsp_valid_ff && rsp_stall);
   end

   // running state and output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff     <= '0;
         old_ff       <= '0;
         new_ff       <= '0;
         hunk_ff      <= '0;
         add_ff       <= '0;
         del_ff       <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lines_ff     <= lines_in;
         old_ff       <= old_in;
         new_ff       <= new_in;
         hunk_ff      <= hunk_in;
         add_ff       <= add_in;
         del_ff       <= del_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_limit_ff <= LINE_LENGTH_LIMIT_RESET;
         cnt_limit_ff <= LINE_COUNT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_LINE_LENGTH_LIMIT) len_limit_ff <= csr_wdata;
         if (csr_index == CSR_LINE_COUNT_LIMIT) cnt_limit_ff <= csr_wdata;
      end
   end

endmodule

[src/unified_diff_line_classifier.sv]
// path: a line's event is registered in the line queue, its result in the output register
// throughput: the front parser takes one text byte per cycle while the four-entry line
//   queue has room; the back end drains one queue entry per cycle unless its result stalls
// reset: synchronous, active high; clears all parse state and totals and returns the
//   limits to 256 and 4096; no clearing pass, ready for input in the cycle after reset
module unified_diff_line_classifier
   import udlc_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int EV_WIDTH = $bits(line_event_type) + 2 * NUMBER_WIDTH;

   logic                    byte_accept;
   logic                    q_full;
   logic                    push_valid;
   line_event_type          push_ev;
   logic [NUMBER_WIDTH-1:0] push_old, push_new;
   logic                    pop_valid, pop_ready;
   logic [EV_WIDTH-1:0]     pop_data;
   line_event_type          pop_ev;
   logic [NUMBER_WIDTH-1:0] pop_old, pop_new;

   // input transfer
   assign req_stall   = q_full;
   assign byte_accept = req_valid && !req_stall;

   udlc_front #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .byte_accept   (byte_accept),
      .byte_payload  (req_payload),
      .ev_valid      (push_valid),
      .ev            (push_ev),
      .ev_parsed_old (push_old),
      .ev_parsed_new (push_new)
   );

   udlc_queue #(
      .WIDTH(EV_WIDTH),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_old, push_new, push_ev}),
      .full       (q_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   // unpack queue head
   assign {pop_old, pop_new, pop_ev} = pop_data;

   udlc_back #(
      .NUMBER_WIDTH(NUMBER_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .ev_valid      (pop_valid),
      .ev            (pop_ev),
      .ev_parsed_old (pop_old),
      .ev_parsed_new (pop_new),
      .ev_ready      (pop_ready),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

endmodule

[src/udlc_checker.sv]
module udlc_checker
   import udlc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   // a capacity error always closes the text
   a_error_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.parse_status |-> rsp_payload.text_done)
      else $error("capacity error without text end");

   // a capacity error carries no line numbers
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.parse_status |->
         rsp_payload.line_kind == KIND_HUNK && rsp_payload.old_number == '0 &&
         rsp_payload.new_number == '0)
      else $error("capacity error with line data");

   // header lines carry no line numbers
   a_header_numbers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.line_kind == KIND_HEADER |->
         rsp_payload.old_number == '0 && rsp_payload.new_number == '0)
      else $error("header line with line numbers");

endmodule

bind unified_diff_line_classifier udlc_checker u_checker (.*);
